// ===== hdl/hrhp_pkg.sv =====
// Shared codes, header name strings and helper functions for the response parser.
`default_nettype none
package hrhp_pkg;

	// input command codes
	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_END   = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_VERDICT = 2'd0;
	localparam logic [1:0] KIND_BODY    = 2'd1;
	localparam logic [1:0] KIND_BROKEN  = 2'd2;

	// verdict codes
	localparam logic [2:0] V_WHOLE      = 3'd0;
	localparam logic [2:0] V_RANGE      = 3'd1;
	localparam logic [2:0] V_HDR_ERR    = 3'd2;
	localparam logic [2:0] V_RANGE_ERR  = 3'd3;
	localparam logic [2:0] V_STATUS_ERR = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_ASKED_OFFSET  = 2'd0;
	localparam logic [1:0] REG_KNOWN_TOTAL   = 2'd1;
	localparam logic [1:0] REG_WRITER_ACTIVE = 2'd2;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LOW_I = 8'h69;

	// strings, right aligned in an 18 character field
	localparam logic [143:0] STR_LENGTH = "content-length:";
	localparam logic [143:0] STR_RANGE  = "content-range:";
	localparam logic [143:0] STR_TE     = "transfer-encoding:";
	localparam logic [143:0] STR_STATUS = "HTTP/1.";
	localparam logic [143:0] STR_BYTES  = "bytes ";
	localparam logic [4:0] LEN_LENGTH = 5'd15;
	localparam logic [4:0] LEN_RANGE  = 5'd14;
	localparam logic [4:0] LEN_TE     = 5'd18;
	localparam logic [4:0] LEN_STATUS = 5'd7;
	localparam logic [4:0] LEN_BYTES  = 5'd6;

	localparam logic [15:0] STATUS_OK      = 16'd200;
	localparam logic [15:0] STATUS_PARTIAL = 16'd206;

	// header fields gathered over the lines of one response
	typedef struct packed {
		logic [31:0] status_value;
		logic        length_valid;
		logic [31:0] length_value;
		logic        range_valid;
		logic [31:0] range_first;
		logic [31:0] range_total;
		logic        chunked_seen;
	} hdr_t;

	// character i of a string of length len
	function automatic logic [7:0] str_char(logic [143:0] s, logic [4:0] len, logic [4:0] i);
		logic [4:0] b;
		b = len - 5'd1 - i;
		return s[{b, 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] to_lower(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/hrhp_line_walker.sv =====
// Walks one stored header line a character at a time and updates the header fields.
`default_nettype none
module hrhp_line_walker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         clear,
	input  wire logic         line_start,
	input  wire logic         status_mode,
	input  wire logic         chr_valid,
	input  wire logic [7:0]   chr,
	output hrhp_pkg::hdr_t    hdr
);

	localparam logic [3:0] W_DONE    = 4'd0;
	localparam logic [3:0] W_PREFIX  = 4'd1;
	localparam logic [3:0] W_SKIPNS  = 4'd2;
	localparam logic [3:0] W_SKIPSP  = 4'd3;
	localparam logic [3:0] W_SNUM    = 4'd4;
	localparam logic [3:0] W_NAME    = 4'd5;
	localparam logic [3:0] W_LBL     = 4'd6;
	localparam logic [3:0] W_LNUM    = 4'd7;
	localparam logic [3:0] W_RBL     = 4'd8;
	localparam logic [3:0] W_RBYTES  = 4'd9;
	localparam logic [3:0] W_RFIRST  = 4'd10;
	localparam logic [3:0] W_RLAST   = 4'd11;
	localparam logic [3:0] W_RTOTAL  = 4'd12;
	localparam logic [3:0] W_TBL     = 4'd13;

	logic [3:0]     st_q, st_d, st_eff;
	logic [4:0]     idx_q, idx_d;
	logic [2:0]     alive_q, alive_d, hits;
	logic [31:0]    acc_q, acc_d;
	logic           any_q, any_d;
	logic [31:0]    rlast_q, rlast_d;
	hrhp_pkg::hdr_t hdr_q, hdr_d;

	logic        digit, blank, ovf;
	logic [7:0]  lc;
	logic [35:0] prod;

	assign hdr = hdr_q;

	// character classes and the decimal step acc*10+d
	always_comb begin
		digit = chr >= 8'h30 && chr <= 8'h39;
		blank = chr == hrhp_pkg::CH_SP || chr == hrhp_pkg::CH_TAB;
		lc    = hrhp_pkg::to_lower(chr);
		prod  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, chr[3:0] - 4'd0};
		ovf   = prod[35:32] != 4'd0;
		hits[0] = alive_q[0] && idx_q < hrhp_pkg::LEN_LENGTH &&
			lc == hrhp_pkg::str_char(hrhp_pkg::STR_LENGTH, hrhp_pkg::LEN_LENGTH, idx_q);
		hits[1] = alive_q[1] && idx_q < hrhp_pkg::LEN_RANGE &&
			lc == hrhp_pkg::str_char(hrhp_pkg::STR_RANGE, hrhp_pkg::LEN_RANGE, idx_q);
		hits[2] = alive_q[2] && idx_q < hrhp_pkg::LEN_TE &&
			lc == hrhp_pkg::str_char(hrhp_pkg::STR_TE, hrhp_pkg::LEN_TE, idx_q);
	end

	// per character parse step; blank skips fall through to the following state
	always_comb begin
		st_d    = st_q;
		idx_d   = idx_q;
		alive_d = alive_q;
		acc_d   = acc_q;
		any_d   = any_q;
		rlast_d = rlast_q;
		hdr_d   = hdr_q;
		st_eff  = st_q;
		if (st_q == W_SKIPSP && chr != hrhp_pkg::CH_SP)
			st_eff = W_SNUM;
		if (st_q == W_LBL && !blank)
			st_eff = W_LNUM;
		if (st_q == W_RBL && !blank)
			st_eff = W_RBYTES;
		case (st_eff)
			W_PREFIX: begin
				if (chr == hrhp_pkg::str_char(hrhp_pkg::STR_STATUS, hrhp_pkg::LEN_STATUS, idx_q)) begin
					if (idx_q == hrhp_pkg::LEN_STATUS - 5'd1)
						st_d = W_SKIPNS;
					else
						idx_d = idx_q + 5'd1;
				end else begin
					hdr_d.status_value = 32'd0;
					st_d = W_DONE;
				end
			end
			W_SKIPNS: begin
				acc_d = 32'd0;
				any_d = 1'b0;
				if (chr == hrhp_pkg::CH_SP)
					st_d = W_SKIPSP;
				else if (chr == hrhp_pkg::CH_NUL) begin
					hdr_d.status_value = 32'd0;
					st_d = W_DONE;
				end
			end
			// still in a run of blanks: hold the state
			W_SKIPSP, W_LBL, W_RBL: begin
				st_d = st_q;
			end
			W_SNUM: begin
				st_d = W_SNUM;
				if (digit && ovf) begin
					hdr_d.status_value = 32'd0;
					st_d = W_DONE;
				end else if (digit) begin
					acc_d = prod[31:0];
					any_d = 1'b1;
				end else begin
					hdr_d.status_value = acc_q;
					st_d = W_DONE;
				end
			end
			W_NAME: begin
				acc_d = 32'd0;
				any_d = 1'b0;
				if (hits[0] && idx_q == hrhp_pkg::LEN_LENGTH - 5'd1)
					st_d = W_LBL;
				else if (hits[1] && idx_q == hrhp_pkg::LEN_RANGE - 5'd1) begin
					st_d  = W_RBL;
					idx_d = 5'd0;
				end else if (hits[2] && idx_q == hrhp_pkg::LEN_TE - 5'd1)
					st_d = W_TBL;
				else if (hits == 3'b000)
					st_d = W_DONE;
				else begin
					alive_d = hits;
					idx_d   = idx_q + 5'd1;
				end
			end
			W_LNUM: begin
				st_d = W_LNUM;
				if (digit && ovf) begin
					hdr_d.length_valid = 1'b0;
					st_d = W_DONE;
				end else if (digit) begin
					acc_d = prod[31:0];
					any_d = 1'b1;
				end else begin
					hdr_d.length_valid = any_q;
					hdr_d.length_value = acc_q;
					st_d = W_DONE;
				end
			end
			W_RBYTES: begin
				st_d = W_RBYTES;
				if (chr == hrhp_pkg::str_char(hrhp_pkg::STR_BYTES, hrhp_pkg::LEN_BYTES, idx_q)) begin
					if (idx_q == hrhp_pkg::LEN_BYTES - 5'd1)
						st_d = W_RFIRST;
					else
						idx_d = idx_q + 5'd1;
				end else
					st_d = W_DONE;
			end
			W_RFIRST: begin
				if (digit && ovf) begin
					hdr_d.range_valid = 1'b0;
					st_d = W_DONE;
				end else if (digit) begin
					acc_d = prod[31:0];
					any_d = 1'b1;
				end else begin
					hdr_d.range_first = acc_q;
					acc_d = 32'd0;
					any_d = 1'b0;
					if (any_q && chr == hrhp_pkg::CH_DASH)
						st_d = W_RLAST;
					else begin
						hdr_d.range_valid = 1'b0;
						st_d = W_DONE;
					end
				end
			end
			W_RLAST: begin
				if (digit && ovf) begin
					hdr_d.range_valid = 1'b0;
					st_d = W_DONE;
				end else if (digit) begin
					acc_d = prod[31:0];
					any_d = 1'b1;
				end else begin
					rlast_d = acc_q;
					acc_d = 32'd0;
					any_d = 1'b0;
					if (any_q && chr == hrhp_pkg::CH_SLASH)
						st_d = W_RTOTAL;
					else begin
						hdr_d.range_valid = 1'b0;
						st_d = W_DONE;
					end
				end
			end
			W_RTOTAL: begin
				if (digit && ovf) begin
					hdr_d.range_valid = 1'b0;
					st_d = W_DONE;
				end else if (digit) begin
					acc_d = prod[31:0];
					any_d = 1'b1;
				end else begin
					hdr_d.range_total = acc_q;
					hdr_d.range_valid = any_q && rlast_q < acc_q && hdr_q.range_first <= rlast_q;
					st_d = W_DONE;
				end
			end
			W_TBL: begin
				if (!blank) begin
					hdr_d.chunked_seen = lc != hrhp_pkg::CH_LOW_I;
					st_d = W_DONE;
				end
			end
			default: begin
				st_d = W_DONE;
			end
		endcase
	end

	// walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= W_DONE;
			idx_q   <= 5'd0;
			alive_q <= 3'b000;
			any_q   <= 1'b0;
			hdr_q   <= '0;
		end else if (clear) begin
			st_q                <= W_DONE;
			hdr_q.status_value  <= 32'd0;
			hdr_q.length_valid  <= 1'b0;
			hdr_q.range_valid   <= 1'b0;
			hdr_q.chunked_seen  <= 1'b0;
		end else if (line_start) begin
			st_q    <= status_mode ? W_PREFIX : W_NAME;
			idx_q   <= 5'd0;
			alive_q <= 3'b111;
			any_q   <= 1'b0;
		end else if (chr_valid) begin
			st_q    <= st_d;
			idx_q   <= idx_d;
			alive_q <= alive_d;
			any_q   <= any_d;
			hdr_q   <= hdr_d;
		end
	end

	// number accumulators
	always_ff @(posedge clk) begin
		if (line_start)
			acc_q <= 32'd0;
		else if (chr_valid) begin
			acc_q   <= acc_d;
			rlast_q <= rlast_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/http_response_header_parser_unit.sv =====
// Top level of the response parser: line memory, phase control, verdict and body pass-through.
// Latency: a result is registered and shown on the cycle after its request is accepted.
// Throughput: header and body bytes are taken while no line walk is busy and the output is
// not stalled; a non-blank header line end walks the line memory one entry per cycle.
// Reset: phase idle, all header fields and configuration registers zero; the line
// memory is not cleared and needs no clearing pass.
`default_nettype none
module http_response_header_parser_unit #(
	parameter int LINE_BYTES = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [2:0]       verdict,
	output logic [31:0]      content_length,
	output logic [7:0]       body_byte,
	output logic             last_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int DEPTH = LINE_BYTES - 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(LINE_BYTES);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_BODY   = 3'd2;
	localparam logic [2:0] PH_DONE   = 3'd3;
	localparam logic [2:0] PH_FAILED = 3'd4;
	localparam logic [2:0] PH_BROKEN = 3'd5;

	logic [7:0]  line_mem [DEPTH];
	logic [7:0]  rdata_s1;
	logic        rv_s1, rlast_s1;

	logic [31:0] asked_offset_q, known_total_q;
	logic        writer_active_q;

	logic [2:0]    phase_q;
	logic [CW-1:0] cnt_q, wcnt_q, ridx_q, trimmed;
	logic          ovf_q, lastcr_q, sls_q, busy_q, idone_q;
	logic [31:0]   rem_q;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [2:0]  verdict_q;
	logic [31:0] cl_q;
	logic [7:0]  body_q;
	logic        last_q;

	logic           acc, is_byte, is_lf, line_start, status_mode, blank_line;
	logic [2:0]     v;
	logic [32:0]    range_sum;
	hrhp_pkg::hdr_t hdr;

	assign cfg_ready      = 1'b1;
	assign in_ready       = !busy_q && (!out_valid_q || out_ready);
	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign verdict        = verdict_q;
	assign content_length = cl_q;
	assign body_byte      = body_q;
	assign last_byte      = last_q;

	// request decode
	always_comb begin
		acc         = in_valid && in_ready;
		is_byte     = acc && cmd == hrhp_pkg::CMD_BYTE;
		is_lf       = is_byte && phase_q == PH_HEADER && data_byte == hrhp_pkg::CH_LF;
		trimmed     = (cnt_q != '0 && lastcr_q) ? cnt_q - CW'(1) : cnt_q;
		blank_line  = is_lf && trimmed == '0 && !ovf_q && sls_q;
		line_start  = is_lf && !blank_line && !ovf_q;
		status_mode = !sls_q;
	end

	// verdict from the gathered header fields
	always_comb begin
		range_sum = {1'b0, hdr.range_first} + {1'b0, hdr.length_value};
		if (hdr.chunked_seen || !hdr.length_valid)
			v = hrhp_pkg::V_HDR_ERR;
		else if (hdr.status_value == 32'(hrhp_pkg::STATUS_PARTIAL)) begin
			if (!hdr.range_valid || hdr.range_first != asked_offset_q ||
				range_sum != {1'b0, hdr.range_total} ||
				(known_total_q != 32'd0 && hdr.range_total != known_total_q) ||
				!writer_active_q)
				v = hrhp_pkg::V_RANGE_ERR;
			else
				v = hrhp_pkg::V_RANGE;
		end else if (hdr.status_value == 32'(hrhp_pkg::STATUS_OK))
			v = hrhp_pkg::V_WHOLE;
		else
			v = hrhp_pkg::V_STATUS_ERR;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asked_offset_q  <= 32'd0;
			known_total_q   <= 32'd0;
			writer_active_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				hrhp_pkg::REG_ASKED_OFFSET:  asked_offset_q  <= cfg_data;
				hrhp_pkg::REG_KNOWN_TOTAL:   known_total_q   <= cfg_data;
				hrhp_pkg::REG_WRITER_ACTIVE: writer_active_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// line memory: write while gathering, read while walking
	always_ff @(posedge clk) begin
		if (is_byte && phase_q == PH_HEADER && !is_lf && cnt_q < FULL)
			line_mem[cnt_q[AW-1:0]] <= data_byte;
		if (busy_q && !idone_q && ridx_q < wcnt_q)
			rdata_s1 <= line_mem[ridx_q[AW-1:0]];
	end

	// walk sequencer: one read per cycle, a terminating zero after the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			idone_q  <= 1'b0;
			ridx_q   <= '0;
			wcnt_q   <= '0;
			rv_s1    <= 1'b0;
			rlast_s1 <= 1'b0;
		end else begin
			rv_s1    <= busy_q && !idone_q;
			rlast_s1 <= ridx_q == wcnt_q;
			if (line_start) begin
				busy_q  <= 1'b1;
				idone_q <= 1'b0;
				ridx_q  <= '0;
				wcnt_q  <= trimmed;
			end else begin
				if (busy_q && !idone_q) begin
					ridx_q <= ridx_q + CW'(1);
					if (ridx_q == wcnt_q)
						idone_q <= 1'b1;
				end
				if (rv_s1 && rlast_s1)
					busy_q <= 1'b0;
			end
		end
	end

	hrhp_line_walker u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (acc && cmd == hrhp_pkg::CMD_START),
		.line_start  (line_start),
		.status_mode (status_mode),
		.chr_valid   (rv_s1),
		.chr         (rlast_s1 ? hrhp_pkg::CH_NUL : rdata_s1),
		.hdr         (hdr)
	);

	// phase, line gathering and body count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			lastcr_q <= 1'b0;
			sls_q    <= 1'b0;
			rem_q    <= 32'd0;
		end else if (acc) begin
			case (cmd)
				hrhp_pkg::CMD_START: begin
					phase_q  <= PH_HEADER;
					cnt_q    <= '0;
					ovf_q    <= 1'b0;
					lastcr_q <= 1'b0;
					sls_q    <= 1'b0;
				end
				hrhp_pkg::CMD_END: begin
					if (phase_q == PH_HEADER || phase_q == PH_BODY)
						phase_q <= PH_BROKEN;
				end
				hrhp_pkg::CMD_BYTE: begin
					if (phase_q == PH_HEADER) begin
						if (is_lf) begin
							cnt_q    <= '0;
							ovf_q    <= 1'b0;
							lastcr_q <= 1'b0;
							if (line_start)
								sls_q <= 1'b1;
							if (blank_line) begin
								if (v == hrhp_pkg::V_WHOLE || v == hrhp_pkg::V_RANGE) begin
									rem_q   <= hdr.length_value;
									phase_q <= (hdr.length_value == 32'd0) ? PH_DONE : PH_BODY;
								end else
									phase_q <= PH_FAILED;
							end
						end else if (cnt_q < FULL) begin
							cnt_q    <= cnt_q + CW'(1);
							lastcr_q <= data_byte == hrhp_pkg::CH_CR;
						end else
							ovf_q <= 1'b1;
					end else if (phase_q == PH_BODY) begin
						if (rem_q == 32'd0)
							phase_q <= PH_DONE;
						else begin
							rem_q <= rem_q - 32'd1;
							if (rem_q == 32'd1)
								phase_q <= PH_DONE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (acc && cmd == hrhp_pkg::CMD_END &&
			(phase_q == PH_HEADER || phase_q == PH_BODY))
			out_valid_q <= 1'b1;
		else if (blank_line)
			out_valid_q <= 1'b1;
		else if (is_byte && phase_q == PH_BODY && rem_q != 32'd0)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q    <= hrhp_pkg::KIND_BROKEN;
			verdict_q <= hrhp_pkg::V_WHOLE;
			cl_q      <= 32'd0;
			body_q    <= 8'd0;
			last_q    <= 1'b0;
			if (blank_line) begin
				kind_q    <= hrhp_pkg::KIND_VERDICT;
				verdict_q <= v;
				cl_q      <= hdr.length_valid ? hdr.length_value : 32'd0;
			end else if (is_byte && phase_q == PH_BODY) begin
				kind_q <= hrhp_pkg::KIND_BODY;
				body_q <= data_byte;
				last_q <= rem_q == 32'd1;
			end
		end
	end

endmodule
`default_nettype wire
